@@ rtl/ehorn_pkg.sv @@
`default_nettype none
package ehorn_pkg;

  localparam int MAX_TERMS  = 64;
  localparam int FRAC_BITS  = 24;
  localparam int X_W        = 16;
  localparam int X_FRAC     = 11;
  localparam int OUT_W      = 48;
  localparam int TERM_W     = 7;
  localparam int TERM_RESET = 25;
  localparam int STEP_W     = $clog2(MAX_TERMS);

  // limb engine: the working word is split over LIMBS cells of LIMB_W bits
  localparam int LIMB_W  = 16;
  localparam int LIMBS   = 4;
  localparam int WORD_W  = LIMB_W * LIMBS;
  localparam int SUB_W   = $clog2(LIMBS);
  localparam int RECIP_W = FRAC_BITS + 1;
  localparam int MULT_W  = RECIP_W + 1;
  localparam int PROD_W  = LIMB_W + 1 + MULT_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ACC_W   = SUM_W - LIMB_W;
  localparam int Q_W     = ACC_W + WORD_W - FRAC_BITS;

  localparam int RONE = 1 << FRAC_BITS;

  // reciprocal of the divisor, rounded to nearest; the entry for zero is never read
  localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_TERMS] = '{
    RECIP_W'(RONE),                RECIP_W'((RONE + 1/2) / 1),
    RECIP_W'((RONE + 2/2) / 2),    RECIP_W'((RONE + 3/2) / 3),
    RECIP_W'((RONE + 4/2) / 4),    RECIP_W'((RONE + 5/2) / 5),
    RECIP_W'((RONE + 6/2) / 6),    RECIP_W'((RONE + 7/2) / 7),
    RECIP_W'((RONE + 8/2) / 8),    RECIP_W'((RONE + 9/2) / 9),
    RECIP_W'((RONE + 10/2) / 10),  RECIP_W'((RONE + 11/2) / 11),
    RECIP_W'((RONE + 12/2) / 12),  RECIP_W'((RONE + 13/2) / 13),
    RECIP_W'((RONE + 14/2) / 14),  RECIP_W'((RONE + 15/2) / 15),
    RECIP_W'((RONE + 16/2) / 16),  RECIP_W'((RONE + 17/2) / 17),
    RECIP_W'((RONE + 18/2) / 18),  RECIP_W'((RONE + 19/2) / 19),
    RECIP_W'((RONE + 20/2) / 20),  RECIP_W'((RONE + 21/2) / 21),
    RECIP_W'((RONE + 22/2) / 22),  RECIP_W'((RONE + 23/2) / 23),
    RECIP_W'((RONE + 24/2) / 24),  RECIP_W'((RONE + 25/2) / 25),
    RECIP_W'((RONE + 26/2) / 26),  RECIP_W'((RONE + 27/2) / 27),
    RECIP_W'((RONE + 28/2) / 28),  RECIP_W'((RONE + 29/2) / 29),
    RECIP_W'((RONE + 30/2) / 30),  RECIP_W'((RONE + 31/2) / 31),
    RECIP_W'((RONE + 32/2) / 32),  RECIP_W'((RONE + 33/2) / 33),
    RECIP_W'((RONE + 34/2) / 34),  RECIP_W'((RONE + 35/2) / 35),
    RECIP_W'((RONE + 36/2) / 36),  RECIP_W'((RONE + 37/2) / 37),
    RECIP_W'((RONE + 38/2) / 38),  RECIP_W'((RONE + 39/2) / 39),
    RECIP_W'((RONE + 40/2) / 40),  RECIP_W'((RONE + 41/2) / 41),
    RECIP_W'((RONE + 42/2) / 42),  RECIP_W'((RONE + 43/2) / 43),
    RECIP_W'((RONE + 44/2) / 44),  RECIP_W'((RONE + 45/2) / 45),
    RECIP_W'((RONE + 46/2) / 46),  RECIP_W'((RONE + 47/2) / 47),
    RECIP_W'((RONE + 48/2) / 48),  RECIP_W'((RONE + 49/2) / 49),
    RECIP_W'((RONE + 50/2) / 50),  RECIP_W'((RONE + 51/2) / 51),
    RECIP_W'((RONE + 52/2) / 52),  RECIP_W'((RONE + 53/2) / 53),
    RECIP_W'((RONE + 54/2) / 54),  RECIP_W'((RONE + 55/2) / 55),
    RECIP_W'((RONE + 56/2) / 56),  RECIP_W'((RONE + 57/2) / 57),
    RECIP_W'((RONE + 58/2) / 58),  RECIP_W'((RONE + 59/2) / 59),
    RECIP_W'((RONE + 60/2) / 60),  RECIP_W'((RONE + 61/2) / 61),
    RECIP_W'((RONE + 62/2) / 62),  RECIP_W'((RONE + 63/2) / 63)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_SHIFT,
    ST_MUL_R,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic             enable;
    logic             first;
    logic             top;
    logic [ACC_W-1:0] init;
  } mac_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/ehorn_cell.sv @@
`default_nettype none
module ehorn_cell (
  input  logic                         clk,
  input  ehorn_pkg::cell_ctrl_t        ctrl,
  input  logic [ehorn_pkg::LIMB_W-1:0] load_data,
  input  logic [ehorn_pkg::LIMB_W-1:0] shift_in,
  output logic [ehorn_pkg::LIMB_W-1:0] limb
);
  import ehorn_pkg::*;

  // parallel load wins over the shift toward the multiplier end
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      limb <= load_data;
    end else if (ctrl.shift) begin
      limb <= shift_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ehorn_mac.sv @@
`default_nettype none
module ehorn_mac (
  input  logic                                clk,
  input  ehorn_pkg::mac_ctrl_t                ctrl,
  input  logic [ehorn_pkg::LIMB_W-1:0]        limb,
  input  logic signed [ehorn_pkg::MULT_W-1:0] mult,
  output logic [ehorn_pkg::LIMB_W-1:0]        emit,
  output logic signed [ehorn_pkg::ACC_W-1:0]  acc
);
  import ehorn_pkg::*;

  logic signed [LIMB_W:0]   digit;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_in;
  logic signed [SUM_W-1:0]  sum;

  // only the top limb of a word carries the sign
  assign digit  = ctrl.top ? $signed({limb[LIMB_W-1], limb}) : $signed({1'b0, limb});
  assign prod   = digit * mult;
  assign acc_in = ctrl.first ? $signed(ctrl.init) : acc;
  assign sum    = SUM_W'(prod) + SUM_W'(acc_in);
  assign emit   = sum[LIMB_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.enable) begin
      acc <= $signed(sum[SUM_W-1:LIMB_W]);
    end
  end

endmodule
`default_nettype wire

@@ rtl/exp_taylor_horner_top.sv @@
// channel   direction  handshake                 payload
// config    in         cfg_valid / cfg_ready     term_count [6:0]
// input     in         in_valid / in_stall       x_value [15:0] signed, Q5.11
// output    out        out_valid / out_stall     exp_value [47:0] signed Q24.24, overflow
//
// each horner step is a limb pass for the product with x, a realign state, a limb pass for
// the reciprocal and a saturate state; all through the one multiplier
// an item runs its horner steps and then moves its result into the output register, with the
// term count held to 2..64; the next beat is taken the cycle after that
// a stalled result holds in the output register; the engine waits if a second one is ready
// reset clears the control state and sets the held term count to 25
`default_nettype none
module exp_taylor_horner_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ehorn_pkg::TERM_W-1:0]        term_count,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ehorn_pkg::X_W-1:0]    x_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ehorn_pkg::OUT_W-1:0]  exp_value,
  output logic                                overflow
);
  import ehorn_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [TERM_W-1:0]        term_reg;
  logic [SUB_W-1:0]         sub;
  logic [STEP_W-1:0]        step;
  logic [STEP_W-1:0]        step_first;
  logic signed [X_W-1:0]    x_reg;
  logic                     ovf;
  logic                     accept;
  logic                     out_free;
  logic                     last_limb;

  logic [LIMB_W-1:0]        limb [LIMBS];
  logic [WORD_W-1:0]        word;
  logic [WORD_W-1:0]        load_word;
  logic [WORD_W-1:0]        t_word;
  logic [LIMB_W-1:0]        emit;
  logic signed [ACC_W-1:0]  acc;
  logic signed [MULT_W-1:0] mult;
  cell_ctrl_t               cell_ctrl;
  mac_ctrl_t                mac_ctrl;

  logic signed [Q_W-1:0]    q;
  logic signed [Q_W-1:0]    v;
  logic                     sat_hi;
  logic                     sat_lo;
  logic [OUT_W-1:0]         v_clamp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last_limb = (sub == SUB_W'(LIMBS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      term_reg <= TERM_W'(TERM_RESET);
    end else if (cfg_valid && cfg_ready) begin
      term_reg <= term_count;
    end
  end

  always_comb begin
    priority if (term_reg < TERM_W'(2)) begin
      step_first = STEP_W'(1);
    end else if (term_reg > TERM_W'(MAX_TERMS)) begin
      step_first = STEP_W'(MAX_TERMS - 1);
    end else begin
      step_first = STEP_W'(term_reg - TERM_W'(1));
    end
  end

  // limb chain: cell 0 feeds the multiplier, fresh limbs enter at the top
  for (genvar k = 0; k < LIMBS; k++) begin : g_cell
    logic [LIMB_W-1:0] shift_in;
    if (k == LIMBS - 1) begin : g_top
      assign shift_in = emit;
    end else begin : g_mid
      assign shift_in = limb[k+1];
    end
    ehorn_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .load_data (load_word[k*LIMB_W +: LIMB_W]),
      .shift_in  (shift_in),
      .limb      (limb[k])
    );
    assign word[k*LIMB_W +: LIMB_W] = limb[k];
  end

  ehorn_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .limb (limb[0]),
    .mult (mult),
    .emit (emit),
    .acc  (acc)
  );

  // product with x already carries the half-lsb bias, so this is the rounded t
  assign t_word = {{X_FRAC{word[WORD_W-1]}}, word[WORD_W-1:X_FRAC]};

  assign q      = $signed({acc, word[WORD_W-1:FRAC_BITS]});
  assign v      = q + (Q_W'(1) << FRAC_BITS);
  assign sat_hi = !v[Q_W-1] && (v[Q_W-2:OUT_W-1] != '0);
  assign sat_lo = v[Q_W-1] && !(&v[Q_W-2:OUT_W-1]);

  always_comb begin
    priority if (sat_hi) begin
      v_clamp = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (sat_lo) begin
      v_clamp = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      v_clamp = v[OUT_W-1:0];
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE:  load_word = WORD_W'(1) << FRAC_BITS;
      ST_SHIFT: load_word = t_word;
      ST_FIN:   load_word = {{(WORD_W-OUT_W){v_clamp[OUT_W-1]}}, v_clamp};
      default:  load_word = '0;
    endcase
  end

  always_comb begin
    cell_ctrl.load    = accept || (state == ST_SHIFT) || (state == ST_FIN);
    cell_ctrl.shift   = (state == ST_MUL_X) || (state == ST_MUL_R);
    mac_ctrl.enable   = cell_ctrl.shift;
    mac_ctrl.first    = (sub == '0);
    mac_ctrl.top      = last_limb;
    mac_ctrl.init     = (state == ST_MUL_X) ? ACC_W'(1) << (X_FRAC - 1)
                                            : ACC_W'(1) << (FRAC_BITS - 1);
    mult              = (state == ST_MUL_X) ? MULT_W'(x_reg)
                                            : $signed({1'b0, RECIP_TABLE[step]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_MUL_X;
      end
      ST_MUL_X: begin
        if (last_limb) state_next = ST_SHIFT;
      end
      ST_SHIFT: state_next = ST_MUL_R;
      ST_MUL_R: begin
        if (last_limb) state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = (step == STEP_W'(1)) ? ST_DONE : ST_MUL_X;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub  <= '0;
      step <= '0;
      ovf  <= 1'b0;
    end else begin
      if (accept) begin
        sub  <= '0;
        step <= step_first;
        ovf  <= 1'b0;
      end else begin
        if (cell_ctrl.shift) sub <= sub + SUB_W'(1);
        if (state == ST_FIN) begin
          ovf <= ovf | sat_hi | sat_lo;
          if (step != STEP_W'(1)) step <= step - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) x_reg <= x_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      exp_value <= $signed(word[OUT_W-1:0]);
      overflow  <= ovf;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("engine not busy after taking a beat");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (step != '0))
    else $error("divisor index reached zero while busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result presented without finishing an item");

  a_realign_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (sub == '0))
    else $error("limb pass left unaligned");

endmodule
`default_nettype wire
